// ===== src/lfpc_pkg.sv =====
package lfpc_pkg;

  // Default width of the per-message count and of every histogram counter.
  localparam int COUNTER_WIDTH = 32;

  // Default number of entries in the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // One histogram entry for each printable code.
  localparam int HIST_SIZE = 95;
  localparam int IDX_W = 7;
  localparam int VALUE_W = 32;

  localparam logic [7:0] PRINT_LOW = 8'd32;
  localparam logic [7:0] PRINT_HIGH = 8'd126;
  localparam logic [2:0] HEADER_LEN = 3'd4;

  localparam logic KIND_COUNT = 1'b0;
  localparam logic KIND_HIST = 1'b1;

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_ABORT = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  // Work handed from the front to the back. One item may both bump a
  // histogram entry and finish a message.
  typedef struct packed {
    logic               inc;   // increment histogram entry idx
    logic               rd;    // return histogram entry idx
    logic               emit;  // return val with kind
    logic               kind;
    logic [IDX_W-1:0]   idx;
    logic [VALUE_W-1:0] val;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== src/lfpc_ram.sv =====
module lfpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 95
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/lfpc_queue.sv =====
module lfpc_queue #(
  parameter int DEPTH = lfpc_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lfpc_pkg::entry_t  push_data_i,
  input  logic              pop_i,
  output lfpc_pkg::entry_t  head_o,
  output lfpc_pkg::qstat_t  stat_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lfpc_pkg::entry_t slot_q [DEPTH];
  logic [AW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

  assign head_o = slot_q[rptr_q];
  assign stat_o.full = (cnt_q == CW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

// ===== src/lfpc_front.sv =====
module lfpc_front #(
  parameter int COUNTER_WIDTH = lfpc_pkg::COUNTER_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [1:0]        command_i,
  input  logic [7:0]        data_byte_i,
  input  logic [6:0]        char_index_i,
  output logic              push_o,
  output lfpc_pkg::entry_t  entry_o
);

  logic [31:0] hdr_shift_q, hdr_shift_d;
  logic [2:0]  hdr_cnt_q, hdr_cnt_d;
  logic [31:0] remain_q, remain_d;
  logic [COUNTER_WIDTH-1:0] count_q, count_d;

  logic [31:0] shift_new;
  logic [2:0]  cnt_new;
  logic [31:0] remain_new;
  logic [COUNTER_WIDTH-1:0] count_new;
  logic printable;

  assign shift_new = {hdr_shift_q[23:0], data_byte_i};
  assign cnt_new = hdr_cnt_q + 3'd1;
  assign remain_new = remain_q - 32'd1;
  assign printable = (data_byte_i >= lfpc_pkg::PRINT_LOW) &&
                     (data_byte_i <= lfpc_pkg::PRINT_HIGH);
  assign count_new = count_q + COUNTER_WIDTH'(printable);

  always_comb begin
    hdr_shift_d = hdr_shift_q;
    hdr_cnt_d = hdr_cnt_q;
    remain_d = remain_q;
    count_d = count_q;
    push_o = 1'b0;
    entry_o = '0;
    if (accept_i) begin
      unique case (lfpc_pkg::cmd_e'(command_i))
        lfpc_pkg::CMD_BYTE: begin
          if (hdr_cnt_q != lfpc_pkg::HEADER_LEN) begin
            if (cnt_new == lfpc_pkg::HEADER_LEN) begin
              remain_d = shift_new;
              hdr_shift_d = '0;
              count_d = '0;
              if (shift_new == '0) begin
                // Empty message: its count is zero and known at once.
                hdr_cnt_d = '0;
                push_o = 1'b1;
                entry_o.emit = 1'b1;
                entry_o.kind = lfpc_pkg::KIND_COUNT;
              end else begin
                hdr_cnt_d = cnt_new;
              end
            end else begin
              hdr_shift_d = shift_new;
              hdr_cnt_d = cnt_new;
            end
          end else begin
            if (printable) begin
              push_o = 1'b1;
              entry_o.inc = 1'b1;
              entry_o.idx = lfpc_pkg::IDX_W'(data_byte_i - lfpc_pkg::PRINT_LOW);
            end
            if (remain_new == '0) begin
              push_o = 1'b1;
              entry_o.emit = 1'b1;
              entry_o.kind = lfpc_pkg::KIND_COUNT;
              entry_o.val = lfpc_pkg::VALUE_W'(count_new);
              hdr_shift_d = '0;
              hdr_cnt_d = '0;
              remain_d = '0;
              count_d = '0;
            end else begin
              remain_d = remain_new;
              count_d = count_new;
            end
          end
        end
        lfpc_pkg::CMD_ABORT: begin
          hdr_shift_d = '0;
          hdr_cnt_d = '0;
          remain_d = '0;
          count_d = '0;
        end
        lfpc_pkg::CMD_READ: begin
          push_o = 1'b1;
          entry_o.idx = char_index_i;
          if (char_index_i < lfpc_pkg::IDX_W'(lfpc_pkg::HIST_SIZE)) begin
            entry_o.rd = 1'b1;
          end else begin
            // Reads past the last entry return zero without touching memory.
            entry_o.emit = 1'b1;
            entry_o.kind = lfpc_pkg::KIND_HIST;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_shift_q <= '0;
      hdr_cnt_q <= '0;
      remain_q <= '0;
      count_q <= '0;
    end else begin
      hdr_shift_q <= hdr_shift_d;
      hdr_cnt_q <= hdr_cnt_d;
      remain_q <= remain_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== src/lfpc_back.sv =====
module lfpc_back #(
  parameter int COUNTER_WIDTH = lfpc_pkg::COUNTER_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lfpc_pkg::entry_t  head_i,
  input  lfpc_pkg::qstat_t  qstat_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              result_kind_o,
  output logic [31:0]       value_o
);

  localparam int HS = lfpc_pkg::HIST_SIZE;

  lfpc_pkg::entry_t s2_q;
  logic s2_vld_q;
  logic [HS-1:0] vld_q;
  logic fwd_vld_q;
  logic [lfpc_pkg::IDX_W-1:0] fwd_idx_q;
  logic [COUNTER_WIDTH-1:0] fwd_val_q;
  logic out_vld_q;
  logic out_kind_q;
  logic [31:0] out_val_q;

  logic [COUNTER_WIDTH-1:0] rdata, base, bumped;
  logic has_result, retire, advance, wr_en;

  lfpc_ram #(
    .WIDTH (COUNTER_WIDTH),
    .DEPTH (HS)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s2_q.idx),
    .wdata_i (bumped),
    .re_i    (pop_o),
    .raddr_i (head_i.idx),
    .rdata_o (rdata)
  );

  // The newest write wins over the memory, which returns old data when a
  // read and a write of one entry meet at the same edge.
  always_comb begin
    if (fwd_vld_q && (fwd_idx_q == s2_q.idx)) begin
      base = fwd_val_q;
    end else if ((s2_q.inc || s2_q.rd) && vld_q[s2_q.idx]) begin
      base = rdata;
    end else begin
      base = '0;
    end
  end

  assign bumped = base + COUNTER_WIDTH'(1);
  assign has_result = s2_q.emit || s2_q.rd;
  assign retire = s2_vld_q && (!has_result || !out_vld_q || out_ready_i);
  assign advance = !s2_vld_q || retire;
  assign pop_o = advance && !qstat_i.empty;
  assign wr_en = retire && s2_q.inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
      vld_q <= '0;
      fwd_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (pop_o) begin
        s2_vld_q <= 1'b1;
      end else if (retire) begin
        s2_vld_q <= 1'b0;
      end
      if (wr_en) begin
        vld_q[s2_q.idx] <= 1'b1;
        fwd_vld_q <= 1'b1;
      end
      if (retire && has_result) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s2_q <= head_i;
    end
    if (wr_en) begin
      fwd_idx_q <= s2_q.idx;
      fwd_val_q <= bumped;
    end
    if (retire && has_result) begin
      out_kind_q <= s2_q.rd ? lfpc_pkg::KIND_HIST : s2_q.kind;
      out_val_q <= s2_q.rd ? lfpc_pkg::VALUE_W'(base) : s2_q.val;
    end
  end

  assign out_valid_o = out_vld_q;
  assign result_kind_o = out_kind_q;
  assign value_o = out_val_q;

endmodule

// ===== src/length_framed_printable_counter_unit.sv =====
// Length-framed printable byte counter. The input is a byte stream of frames, each a
// four-byte big-endian length followed by that many message bytes; for every message the
// block returns the number of bytes in the printable range 32 to 126 (result_kind 0), and
// a zero length returns a count of zero as soon as its header is complete. Bytes past the
// stated length start the next header and are never counted. A histogram of 95 counters,
// one for each printable code and wrapping at COUNTER_WIDTH bits, runs across messages and
// is cleared only by reset; a read command returns one entry (result_kind 1), and an index
// above 94 returns zero. An abort command drops the partial frame and keeps the histogram.
// Command 3 does nothing. One item is accepted every clock while the two-entry queue has
// room; an accepted item passes from the queue into the back's stage register, and its
// result is registered in the output register, where the receiver takes it. The front
// parses frames in the cycle an item arrives, and the back runs the histogram memory as
// a two-step read-modify-write with forwarding of the last write, so back-to-back
// updates of one counter need no stall. No clearing pass is needed after reset: a valid
// flag for each entry makes an unwritten counter read as zero.

module length_framed_printable_counter_unit #(
  parameter int COUNTER_WIDTH = lfpc_pkg::COUNTER_WIDTH,
  parameter int QUEUE_DEPTH = lfpc_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [7:0]  data_byte_i,
  input  logic [6:0]  char_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [31:0] value_o
);

  logic in_accept;
  logic push;
  logic pop;
  lfpc_pkg::entry_t push_entry;
  lfpc_pkg::entry_t head;
  lfpc_pkg::qstat_t qstat;

  // The front never waits on the back except through the queue filling up.
  assign in_ready_o = !qstat.full;
  assign in_accept = in_valid_i && in_ready_o;

  lfpc_front #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .command_i    (command_i),
    .data_byte_i  (data_byte_i),
    .char_index_i (char_index_i),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  lfpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (qstat)
  );

  lfpc_back #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .qstat_i       (qstat),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .value_o       (value_o)
  );

`ifndef SYNTHESIS
  // The front only hands over work when the queue can take it.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full)
    else $error("push into a full queue");

  // The back only takes work that is there.
  a_pop_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("pop from an empty queue");

  // An abort item produces no work for the back.
  a_abort_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (command_i == lfpc_pkg::CMD_ABORT)) |-> !push)
    else $error("abort item queued work");
`endif

endmodule
